// ===== design/dasd_pkg.sv =====
`timescale 1ns / 1ps

package dasd_pkg;

    // Field widths of the input and result words
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int OFFSET_W = 16;

    // Default number of offset bits that take part in the walk
    localparam int OFFSET_BITS_DEF = 16;

    // Operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // Month numbers
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Day numbers
    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] LEN_31    = 5'd31;
    localparam logic [DAY_W-1:0] LEN_30    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_29    = 5'd29;
    localparam logic [DAY_W-1:0] LEN_28    = 5'd28;

    typedef struct packed {
        logic                kind;
        logic [DAY_W-1:0]    day_in;
        logic [MONTH_W-1:0]  month_in;
        logic [YEAR_W-1:0]   year_in;
        logic [OFFSET_W-1:0] offset_days;
    } t_in_word;

    typedef struct packed {
        logic [DAY_W-1:0]   day_out;
        logic [MONTH_W-1:0] month_out;
        logic [YEAR_W-1:0]  year_out;
        logic               year_wrapped;
    } t_out_word;

    // Date status produced by one month step
    typedef struct packed {
        logic               done;
        logic               wrap;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_step_res;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Month length; leap year when the year is a multiple of four
    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        logic [DAY_W-1:0] len;
        len = LEN_31;
        if (month == MONTH_FEB) begin
            len = (year[1:0] == 2'b00) ? LEN_29 : LEN_28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = LEN_30;
        end
        return len;
    endfunction

endpackage

// ===== design/dasd_step.sv =====
`timescale 1ns / 1ps

module dasd_step
    import dasd_pkg::*;
#(
    parameter int REM_W = OFFSET_BITS_DEF
) (
    input  logic               i_kind,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [REM_W-1:0]   i_rem,
    output t_step_res          o_res,
    output logic [REM_W-1:0]   o_rem
);

    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   room;
    logic [REM_W-1:0]   room_ext;
    logic [REM_W-1:0]   day_ext;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;

    // Days left in the current month after the current day
    assign mlen     = month_len(i_month, i_year);
    assign room     = mlen - i_day;
    assign room_ext = {{(REM_W-DAY_W){1'b0}}, room};
    assign day_ext  = {{(REM_W-DAY_W){1'b0}}, i_day};

    // Previous month, borrowing from the year
    assign prev_month = (i_month == MONTH_JAN) ? MONTH_DEC : i_month - 4'd1;
    assign prev_year  = (i_month == MONTH_JAN) ? i_year - 16'd1 : i_year;

    // One month step: finish inside this month or move to its neighbor
    always_comb begin
        o_res.done  = 1'b0;
        o_res.wrap  = 1'b0;
        o_res.day   = i_day;
        o_res.month = i_month;
        o_res.year  = i_year;
        o_rem       = i_rem;
        if (i_kind == OP_ADD) begin
            if (i_rem <= room_ext) begin
                o_res.done = 1'b1;
                o_res.day  = i_day + i_rem[DAY_W-1:0];
            end else begin
                o_rem     = i_rem - room_ext - {{(REM_W-1){1'b0}}, 1'b1};
                o_res.day = DAY_FIRST;
                if (i_month == MONTH_DEC) begin
                    o_res.month = MONTH_JAN;
                    o_res.year  = i_year + 16'd1;
                    o_res.wrap  = (i_year == {YEAR_W{1'b1}});
                end else begin
                    o_res.month = i_month + 4'd1;
                end
            end
        end else begin
            if (i_rem < day_ext) begin
                o_res.done = 1'b1;
                o_res.day  = i_day - i_rem[DAY_W-1:0];
            end else begin
                // land on the last day of the previous month
                o_rem       = i_rem - day_ext;
                o_res.month = prev_month;
                o_res.year  = prev_year;
                o_res.day   = month_len(prev_month, prev_year);
                o_res.wrap  = (i_month == MONTH_JAN) && (i_year == {YEAR_W{1'b0}});
            end
        end
    end

endmodule

// ===== design/date_add_subtract_days.sv =====
// Calendar date plus or minus a day count. A word carries a date and an
// offset; the result word carries the new date and a flag that is set when
// the year crossed 65535 or 0 (the year wraps modulo 65536). Month 0 reads
// as January, months 13-15 as December, day 0 as day 1, and a day past the
// end of its month as the last day. February has 29 days in years that are
// multiples of four. One month-step unit walks the date a month per cycle;
// the result goes to the output register when the walk is done, and the
// next word is taken only once the unit is back in idle, so one word is
// walked at a time. A result still stalled in the output register holds the
// walk at its last step until the register frees. A new word is taken while
// the previous result may still wait in the output register. Only the low
// OFFSET_BITS bits of the offset (at most 16) are used.
`timescale 1ns / 1ps

module date_add_subtract_days
    import dasd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int REM_W = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;

    t_state             r_state, n_state;
    logic               r_kind, n_kind;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic               r_wrap, n_wrap;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               in_take;
    logic               out_free;
    logic               finish;
    logic [MONTH_W-1:0] clamp_month;
    logic [DAY_W-1:0]   clamp_len;
    logic [DAY_W-1:0]   clamp_day;
    t_step_res          step;
    logic [REM_W-1:0]   step_rem;

    // Shared month-step unit
    dasd_step #(
        .REM_W (REM_W)
    ) u_step (
        .i_kind  (r_kind),
        .i_day   (r_day),
        .i_month (r_month),
        .i_year  (r_year),
        .i_rem   (r_rem),
        .o_res   (step),
        .o_rem   (step_rem)
    );

    // Clamp the starting date into the calendar
    always_comb begin
        if (i_in_word.month_in < MONTH_JAN) begin
            clamp_month = MONTH_JAN;
        end else if (i_in_word.month_in > MONTH_DEC) begin
            clamp_month = MONTH_DEC;
        end else begin
            clamp_month = i_in_word.month_in;
        end
        clamp_len = month_len(clamp_month, i_in_word.year_in);
        if (i_in_word.day_in < DAY_FIRST) begin
            clamp_day = DAY_FIRST;
        end else if (i_in_word.day_in > clamp_len) begin
            clamp_day = clamp_len;
        end else begin
            clamp_day = i_in_word.day_in;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = 1'b1;
        finish     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_RUN:  finish     = step.done && out_free;
            default: o_in_stall = 1'b1;
        endcase
        in_take = i_in_valid && !o_in_stall;
    end

    // Walk registers and output register
    always_comb begin
        n_kind      = r_kind;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_rem       = r_rem;
        n_wrap      = r_wrap;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;
        if (in_take) begin
            n_kind  = i_in_word.kind;
            n_day   = clamp_day;
            n_month = clamp_month;
            n_year  = i_in_word.year_in;
            n_rem   = i_in_word.offset_days[REM_W-1:0];
            n_wrap  = 1'b0;
        end else if (r_state == ST_RUN && !step.done) begin
            n_day   = step.day;
            n_month = step.month;
            n_year  = step.year;
            n_rem   = step_rem;
            n_wrap  = r_wrap || step.wrap;
        end
        if (finish) begin
            n_out_valid             = 1'b1;
            n_out_word.day_out      = step.day;
            n_out_word.month_out    = step.month;
            n_out_word.year_out     = step.year;
            n_out_word.year_wrapped = r_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_day      <= n_day;
        r_month    <= n_month;
        r_year     <= n_year;
        r_rem      <= n_rem;
        r_wrap     <= n_wrap;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
